// ===== hdl/ccd_pkg.sv =====
// Shared constants and types for the chunk cache directory.
`default_nettype none

package ccd_pkg;

   // Directory geometry
   localparam int SLOTS      = 512;
   localparam int CHUNK_LOG2 = 7;
   localparam int COORD_BITS = 16;
   localparam int AGE_BITS   = 48;

   // Derived widths
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int FILL_BITS = $clog2(SLOTS + 1);
   localparam int CC_BITS   = COORD_BITS - CHUNK_LOG2;
   localparam int TAG_BITS  = 3 * CC_BITS;
   localparam int OFF_BITS  = 3 * CHUNK_LOG2;

   localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

   // Access codes
   typedef enum logic [1:0] {
      MODE_READ      = 2'd0,
      MODE_WRITE     = 2'd1,
      MODE_FLUSH     = 2'd2,
      MODE_UNCHECKED = 2'd3
   } mode_type;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_VICTIM = 6'b010000,
      ST_FLUSH  = 6'b100000
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/chunk_cache_directory_lru.sv =====
// Top level of the fully associative chunk cache directory with LRU replacement.
// Current-chunk hit and unchecked write: decided in CHECK and registered; busy holds off a new item
// until the result is strobed. Flush: reads the selected slot, decided in FLUSH. Other misses walk the
// filled slots one per cycle through the tag/age RAM read port, then DECIDE, and VICTIM when one is evicted.
// The receiver cannot stall: each result is strobed on rsp_valid for exactly one cycle.
// Synchronous reset empties the directory at once through a fill count; there is no clearing pass.
`default_nettype none

module chunk_cache_directory_lru (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_mode,
   input  wire logic [15:0] req_coord_a,
   input  wire logic [15:0] req_coord_b,
   input  wire logic [15:0] req_coord_c,
   input  wire logic [8:0]  req_slot_select,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic [8:0]       rsp_slot,
   output logic [20:0]      rsp_offset,
   output logic             rsp_fetch,
   output logic             rsp_writeback,
   output logic [8:0]       rsp_victim_a,
   output logic [8:0]       rsp_victim_b,
   output logic [8:0]       rsp_victim_c
);

   localparam int SB = ccd_pkg::SLOT_BITS;
   localparam int FB = ccd_pkg::FILL_BITS;
   localparam int CB = ccd_pkg::CC_BITS;
   localparam int TB = ccd_pkg::TAG_BITS;
   localparam int OB = ccd_pkg::OFF_BITS;
   localparam int AB = ccd_pkg::AGE_BITS;
   localparam int CL = ccd_pkg::CHUNK_LOG2;
   localparam int XB = ccd_pkg::COORD_BITS;

   // Control state
   ccd_pkg::state_type state_ff, state_in;
   logic [FB-1:0]      fill_ff, fill_in;
   logic [AB-1:0]      use_ff, use_in;
   logic [SB-1:0]      cur_slot_ff, cur_slot_in;
   logic               cur_valid_ff, cur_valid_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic               match_ff, match_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [TB-1:0]      cur_tag_ff, cur_tag_in;
   ccd_pkg::mode_type  mode_ff, mode_in;
   logic [TB-1:0]      tag_ff, tag_in;
   logic [OB-1:0]      off_ff, off_in;
   logic [8:0]         sel_ff, sel_in;
   logic [FB-1:0]      issue_ff, issue_in;
   logic [SB-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [SB-1:0]      match_idx_ff, match_idx_in;
   logic [SB-1:0]      min_idx_ff, min_idx_in;
   logic [AB-1:0]      min_age_ff, min_age_in;

   // Result registers
   logic               hit_ff, hit_in;
   logic [8:0]         slot_ff, slot_in;
   logic [20:0]        offset_ff, offset_in;
   logic               fetch_ff, fetch_in;
   logic               wb_ff, wb_in;
   logic [8:0]         va_ff, va_in;
   logic [8:0]         vb_ff, vb_in;
   logic [8:0]         vc_ff, vc_in;

   // RAM ports
   logic [SB-1:0]      rd_addr;
   logic               tag_we, age_we, dirty_we;
   logic [SB-1:0]      tag_wa, age_wa, dirty_wa;
   logic               dirty_wd;
   logic [TB-1:0]      tag_rd;
   logic [AB-1:0]      age_rd;
   logic               dirty_rd;

   // Request decode
   logic [XB-1:0]      xa, xb, xc;
   logic [TB-1:0]      req_tag;
   logic [OB-1:0]      req_off;
   logic               full;
   logic               sel_ok;
   logic               tag_hit;
   logic [AB-1:0]      use_next;

   assign xa      = XB'(req_coord_a);
   assign xb      = XB'(req_coord_b);
   assign xc      = XB'(req_coord_c);
   assign req_tag = {xa[XB-1:CL], xb[XB-1:CL], xc[XB-1:CL]};
   assign req_off = {xa[CL-1:0], xb[CL-1:0], xc[CL-1:0]};

   assign full     = (fill_ff == FB'(ccd_pkg::SLOTS));
   assign sel_ok   = (32'(sel_ff) < 32'(fill_ff));
   assign tag_hit  = (tag_rd == tag_ff);
   assign use_next = (use_ff != ccd_pkg::AGE_MAX) ? use_ff + AB'(1) : use_ff;

   // Directory stores
   ccd_ram #(.WIDTH(TB), .DEPTH(ccd_pkg::SLOTS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_wa),
      .wr_data (tag_ff),
      .rd_addr (rd_addr),
      .rd_data (tag_rd)
   );

   ccd_ram #(.WIDTH(AB), .DEPTH(ccd_pkg::SLOTS)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (age_wa),
      .wr_data (use_ff),
      .rd_addr (rd_addr),
      .rd_data (age_rd)
   );

   ccd_ram #(.WIDTH(1), .DEPTH(ccd_pkg::SLOTS)) u_dirty_ram (
      .clock   (clock),
      .wr_en   (dirty_we),
      .wr_addr (dirty_wa),
      .wr_data (dirty_wd),
      .rd_addr (rd_addr),
      .rd_data (dirty_rd)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      use_in       = use_ff;
      cur_slot_in  = cur_slot_ff;
      cur_valid_in = cur_valid_ff;
      cur_tag_in   = cur_tag_ff;
      cmp_valid_in = 1'b0;
      match_in     = match_ff;
      rsp_valid_in = 1'b0;
      mode_in      = mode_ff;
      tag_in       = tag_ff;
      off_in       = off_ff;
      sel_in       = sel_ff;
      issue_in     = issue_ff;
      cmp_idx_in   = cmp_idx_ff;
      match_idx_in = match_idx_ff;
      min_idx_in   = min_idx_ff;
      min_age_in   = min_age_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      offset_in    = offset_ff;
      fetch_in     = fetch_ff;
      wb_in        = wb_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      vc_in        = vc_ff;
      rd_addr      = '0;
      tag_we       = 1'b0;
      tag_wa       = '0;
      age_we       = 1'b0;
      age_wa       = '0;
      dirty_we     = 1'b0;
      dirty_wa     = '0;
      dirty_wd     = 1'b0;

      case (state_ff)
         ccd_pkg::ST_IDLE: begin
            if (start) begin
               mode_in  = ccd_pkg::mode_type'(req_mode);
               tag_in   = req_tag;
               off_in   = req_off;
               sel_in   = req_slot_select;
               state_in = ccd_pkg::ST_CHECK;
            end
         end

         ccd_pkg::ST_CHECK: begin
            case (mode_ff)
               ccd_pkg::MODE_FLUSH: begin
                  rd_addr  = SB'(sel_ff);
                  state_in = ccd_pkg::ST_FLUSH;
               end
               ccd_pkg::MODE_UNCHECKED: begin
                  // no lookup, mark the current slot dirty
                  dirty_we     = cur_valid_ff;
                  dirty_wa     = cur_slot_ff;
                  dirty_wd     = 1'b1;
                  hit_in       = cur_valid_ff;
                  slot_in      = 9'(cur_slot_ff);
                  offset_in    = 21'(off_ff);
                  fetch_in     = 1'b0;
                  wb_in        = 1'b0;
                  va_in        = '0;
                  vb_in        = '0;
                  vc_in        = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = ccd_pkg::ST_IDLE;
               end
               default: begin
                  if (cur_valid_ff && (cur_tag_ff == tag_ff)) begin
                     // repeat of the current chunk, ages untouched
                     dirty_we     = (mode_ff == ccd_pkg::MODE_WRITE);
                     dirty_wa     = cur_slot_ff;
                     dirty_wd     = 1'b1;
                     hit_in       = 1'b1;
                     slot_in      = 9'(cur_slot_ff);
                     offset_in    = 21'(off_ff);
                     fetch_in     = 1'b0;
                     wb_in        = 1'b0;
                     va_in        = '0;
                     vb_in        = '0;
                     vc_in        = '0;
                     rsp_valid_in = 1'b1;
                     state_in     = ccd_pkg::ST_IDLE;
                  end else begin
                     match_in = 1'b0;
                     issue_in = '0;
                     state_in = (fill_ff == '0) ? ccd_pkg::ST_DECIDE : ccd_pkg::ST_SCAN;
                  end
               end
            endcase
         end

         ccd_pkg::ST_SCAN: begin
            // issue one slot read a cycle
            if (issue_ff < fill_ff) begin
               rd_addr      = SB'(issue_ff);
               issue_in     = issue_ff + FB'(1);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = SB'(issue_ff);
            end
            // compare the slot read last cycle: tag match and running minimum age
            if (cmp_valid_ff) begin
               if (tag_hit) begin
                  match_in     = 1'b1;
                  match_idx_in = cmp_idx_ff;
               end
               if ((cmp_idx_ff == '0) || (age_rd < min_age_ff)) begin
                  min_age_in = age_rd;
                  min_idx_in = cmp_idx_ff;
               end
               if (tag_hit || (FB'(cmp_idx_ff) + FB'(1) == fill_ff)) begin
                  cmp_valid_in = 1'b0;
                  state_in     = ccd_pkg::ST_DECIDE;
               end
            end
         end

         ccd_pkg::ST_DECIDE: begin
            if (match_ff) begin
               // resident in another slot: refresh its age
               age_we       = 1'b1;
               age_wa       = match_idx_ff;
               use_in       = use_next;
               dirty_we     = (mode_ff == ccd_pkg::MODE_WRITE);
               dirty_wa     = match_idx_ff;
               dirty_wd     = 1'b1;
               cur_slot_in  = match_idx_ff;
               cur_valid_in = 1'b1;
               cur_tag_in   = tag_ff;
               hit_in       = 1'b1;
               slot_in      = 9'(match_idx_ff);
               offset_in    = 21'(off_ff);
               fetch_in     = 1'b0;
               wb_in        = 1'b0;
               va_in        = '0;
               vb_in        = '0;
               vc_in        = '0;
               rsp_valid_in = 1'b1;
               state_in     = ccd_pkg::ST_IDLE;
            end else if (!full) begin
               // first free slot is the next unfilled one
               tag_we       = 1'b1;
               tag_wa       = SB'(fill_ff);
               age_we       = 1'b1;
               age_wa       = SB'(fill_ff);
               use_in       = use_next;
               dirty_we     = 1'b1;
               dirty_wa     = SB'(fill_ff);
               dirty_wd     = (mode_ff == ccd_pkg::MODE_WRITE);
               fill_in      = fill_ff + FB'(1);
               cur_slot_in  = SB'(fill_ff);
               cur_valid_in = 1'b1;
               cur_tag_in   = tag_ff;
               hit_in       = 1'b0;
               slot_in      = 9'(fill_ff);
               offset_in    = 21'(off_ff);
               fetch_in     = 1'b1;
               wb_in        = 1'b0;
               va_in        = '0;
               vb_in        = '0;
               vc_in        = '0;
               rsp_valid_in = 1'b1;
               state_in     = ccd_pkg::ST_IDLE;
            end else begin
               // full: read the victim's tag and dirty mark
               rd_addr  = min_idx_ff;
               state_in = ccd_pkg::ST_VICTIM;
            end
         end

         ccd_pkg::ST_VICTIM: begin
            tag_we       = 1'b1;
            tag_wa       = min_idx_ff;
            age_we       = 1'b1;
            age_wa       = min_idx_ff;
            use_in       = use_next;
            dirty_we     = 1'b1;
            dirty_wa     = min_idx_ff;
            dirty_wd     = (mode_ff == ccd_pkg::MODE_WRITE);
            cur_slot_in  = min_idx_ff;
            cur_valid_in = 1'b1;
            cur_tag_in   = tag_ff;
            hit_in       = 1'b0;
            slot_in      = 9'(min_idx_ff);
            offset_in    = 21'(off_ff);
            fetch_in     = 1'b1;
            wb_in        = dirty_rd;
            va_in        = dirty_rd ? 9'(tag_rd[TB-1 -: CB])     : '0;
            vb_in        = dirty_rd ? 9'(tag_rd[2*CB-1 -: CB])   : '0;
            vc_in        = dirty_rd ? 9'(tag_rd[CB-1:0])         : '0;
            rsp_valid_in = 1'b1;
            state_in     = ccd_pkg::ST_IDLE;
         end

         ccd_pkg::ST_FLUSH: begin
            // slots at or beyond the fill count are reported clean and their dirty mark is left unwritten
            dirty_we     = sel_ok;
            dirty_wa     = SB'(sel_ff);
            dirty_wd     = 1'b0;
            hit_in       = 1'b0;
            slot_in      = sel_ff;
            offset_in    = '0;
            fetch_in     = 1'b0;
            wb_in        = sel_ok & dirty_rd;
            va_in        = (sel_ok & dirty_rd) ? 9'(tag_rd[TB-1 -: CB])   : '0;
            vb_in        = (sel_ok & dirty_rd) ? 9'(tag_rd[2*CB-1 -: CB]) : '0;
            vc_in        = (sel_ok & dirty_rd) ? 9'(tag_rd[CB-1:0])       : '0;
            rsp_valid_in = 1'b1;
            state_in     = ccd_pkg::ST_IDLE;
         end

         default: begin
            state_in = ccd_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccd_pkg::ST_IDLE;
         fill_ff      <= '0;
         use_ff       <= AB'(1);
         cur_slot_ff  <= '0;
         cur_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
         match_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         use_ff       <= use_in;
         cur_slot_ff  <= cur_slot_in;
         cur_valid_ff <= cur_valid_in;
         cmp_valid_ff <= cmp_valid_in;
         match_ff     <= match_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_tag_ff   <= cur_tag_in;
      mode_ff      <= mode_in;
      tag_ff       <= tag_in;
      off_ff       <= off_in;
      sel_ff       <= sel_in;
      issue_ff     <= issue_in;
      cmp_idx_ff   <= cmp_idx_in;
      match_idx_ff <= match_idx_in;
      min_idx_ff   <= min_idx_in;
      min_age_ff   <= min_age_in;
      hit_ff       <= hit_in;
      slot_ff      <= slot_in;
      offset_ff    <= offset_in;
      fetch_ff     <= fetch_in;
      wb_ff        <= wb_in;
      va_ff        <= va_in;
      vb_ff        <= vb_in;
      vc_ff        <= vc_in;
   end

   // Outputs
   assign busy          = (state_ff != ccd_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_slot      = slot_ff;
   assign rsp_offset    = offset_ff;
   assign rsp_fetch     = fetch_ff;
   assign rsp_writeback = wb_ff;
   assign rsp_victim_a  = va_ff;
   assign rsp_victim_b  = vb_ff;
   assign rsp_victim_c  = vc_ff;

   // Checks
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while sequencer busy");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FB'(ccd_pkg::SLOTS))
      else $error("fill count beyond slot count");

   a_fetch_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fetch) |-> !rsp_hit)
      else $error("fetch reported on a hit");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start the sequencer");

endmodule

`default_nettype wire

// ===== hdl/ccd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ccd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
